// ===== rtl/core/min_clock_progress_tracker_macros.svh =====
// Assertion macros used by the checker file.
`ifndef MIN_CLOCK_PROGRESS_TRACKER_MACROS_SVH
`define MIN_CLOCK_PROGRESS_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MCPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcpt: property violated");

// Next-cycle implication, disabled while reset is held.
`define MCPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcpt: property violated");

`endif

// ===== rtl/core/mcpt_pkg.sv =====
package mcpt_pkg;

    localparam int THREADS_DEF          = 64;
    localparam int THREADS_PER_NODE_DEF = 8;
    localparam int MAX_THREADS          = 64;

    localparam int MODE_W  = 2;
    localparam int TID_W   = 6;
    localparam int NODE_W  = 3;
    localparam int CLOCK_W = 32;
    localparam int COUNT_W = 7;
    localparam int MASK_W  = 64;

    localparam logic [CLOCK_W-1:0] CLOCK_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

    // Input transaction, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]        pad;
        logic [NODE_W-1:0] node_id;
        logic [TID_W-1:0]  thread_id;
        logic [MODE_W-1:0] mode;
    } t_item;

    // Result transaction, last field in the lowest bits.
    typedef struct packed {
        logic [6:0]         pad;
        logic               bad_thread;
        logic [COUNT_W-1:0] thread_count;
        logic [CLOCK_W-1:0] thread_clock;
        logic [CLOCK_W-1:0] min_clock;
        logic               min_changed;
    } t_result;

endpackage

// ===== rtl/core/mcpt_ram.sv =====
module mcpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/min_clock_progress_tracker.sv =====
// Minimum-clock progress tracker. Each registered worker thread (up to THREADS) holds a
// 32-bit iteration clock, and the block holds one global minimum clock. Writing
// i_cfg_wdata (one bit per thread) sets the registered set and clears every clock and the
// minimum; write it only while the block is idle. Each input transaction carries a mode:
// 0 advances thread_id's clock (saturating), raising the minimum by one when that thread
// alone held it; 1 drops every registered thread of node_id in ascending order, each drop
// of a lone minimum holder bumping the minimum unless it is saturated; 2 and 3 only
// report. Every input transaction yields exactly one result transaction. Timing: the
// clock memory has one read port and one comparator, so every count of threads at the
// minimum is a scan of THREADS entries, one per cycle. Modes 0, 2 and 3 run one scan.
// Mode 1 steps through each id in the node's range, scans and drops each registered
// thread it finds, and ends with one more scan for the final report. The next input
// transaction is taken as soon as the sequencer is idle, even while a result still
// waits in the output register.
module min_clock_progress_tracker #(
    parameter int THREADS          = mcpt_pkg::THREADS_DEF,
    parameter int THREADS_PER_NODE = mcpt_pkg::THREADS_PER_NODE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration: active_thread_mask
    input  logic                       i_cfg_we,
    input  logic [mcpt_pkg::MASK_W-1:0] i_cfg_wdata,
    // Input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,  // mode[1:0], thread_id[7:2], node_id[10:8]
    // Result stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [79:0]                m_axis_tdata   // min_changed[0], min_clock[32:1],
                                                      // thread_clock[64:33],
                                                      // thread_count[71:65], bad_thread[72]
);

    localparam int IW      = $clog2(THREADS);
    localparam int CW      = $clog2(THREADS + 1);
    localparam int SPAN    = (2 ** mcpt_pkg::NODE_W) * THREADS_PER_NODE;
    localparam int CUR_W   = $clog2(((SPAN > THREADS) ? SPAN : THREADS) + 1);
    localparam int CLK_W   = mcpt_pkg::CLOCK_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_ADVANCE  = 3'd3;
    localparam logic [2:0] ST_NODE     = 3'd4;
    localparam logic [2:0] ST_REMOVE   = 3'd5;
    localparam logic [2:0] ST_REPORT   = 3'd6;
    localparam logic [2:0] ST_OUT      = 3'd7;

    mcpt_pkg::t_item   w_item;
    mcpt_pkg::t_result r_res;
    mcpt_pkg::t_result r_odata;

    logic [2:0]                     r_state;
    logic                           r_ovalid;
    logic [THREADS-1:0]             r_tvalid;   // registered threads
    logic [THREADS-1:0]             r_written;  // clock entry holds data since last clear
    logic [CLK_W-1:0]               r_min;
    logic                           r_changed;
    logic [mcpt_pkg::MODE_W-1:0]    r_mode;
    logic [mcpt_pkg::TID_W-1:0]     r_tid;
    logic [mcpt_pkg::TID_W-1:0]     r_tgt;      // thread whose clock the scan captures
    logic                           r_final;    // scan feeds the report
    logic [CUR_W-1:0]               r_cur;
    logic [CUR_W-1:0]               r_hi;
    logic [IW-1:0]                  r_idx;
    logic [IW-1:0]                  r_pidx;
    logic                           r_pv;
    logic [1:0]                     r_mcnt;     // threads at the minimum, saturating at two
    logic [CW-1:0]                  r_vcnt;
    logic [CLK_W-1:0]               r_sclk;

    logic                           w_accept;
    logic [mcpt_pkg::MASK_W-1:0]    w_valid64;
    logic                           w_tid_reg;
    logic                           w_cur_reg;
    logic [CLK_W-1:0]               w_rdata;
    logic [CLK_W-1:0]               w_eff;
    logic                           w_we;
    logic [CLK_W-1:0]               w_next_clk;
    logic                           w_alone;
    logic [CUR_W-1:0]               w_lo;
    logic [CUR_W-1:0]               w_top;
    logic [CUR_W-1:0]               w_lim;

    assign w_item        = mcpt_pkg::t_item'(s_axis_tdata);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_valid64  = mcpt_pkg::MASK_W'(r_tvalid);
    assign w_tid_reg  = w_valid64[r_tid];
    assign w_cur_reg  = (r_cur < r_hi) && w_valid64[r_cur[mcpt_pkg::TID_W-1:0]];

    // An entry never written since the last clear reads as zero.
    assign w_eff      = r_written[r_pidx] ? w_rdata : '0;
    assign w_alone    = (r_sclk == r_min) && (r_mcnt == 2'd1);
    assign w_next_clk = r_sclk + CLK_W'(1);
    assign w_we       = (r_state == ST_ADVANCE) && w_tid_reg && (r_sclk != mcpt_pkg::CLOCK_MAX);

    // Node range, clipped to the implemented threads.
    assign w_lo  = CUR_W'(w_item.node_id) * CUR_W'(THREADS_PER_NODE);
    assign w_top = w_lo + CUR_W'(THREADS_PER_NODE);
    assign w_lim = (w_top > CUR_W'(THREADS)) ? CUR_W'(THREADS) : w_top;

    mcpt_ram #(
        .WIDTH (CLK_W),
        .DEPTH (THREADS)
    ) u_clocks (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tid[IW-1:0]),
        .i_wdata (w_next_clk),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_tvalid  <= '0;
            r_written <= '0;
            r_min     <= '0;
            r_pv      <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one replaces it at this edge.
            if (m_axis_tvalid && m_axis_tready && (r_state != ST_OUT)) begin
                r_ovalid <= 1'b0;
            end

            // Count and capture one scanned entry per cycle.
            if (r_pv && (r_state == ST_SCAN || r_state == ST_SCAN_END)) begin
                if (r_tvalid[r_pidx]) begin
                    r_vcnt <= r_vcnt + CW'(1);
                    if (w_eff == r_min && r_mcnt != 2'd2) begin
                        r_mcnt <= r_mcnt + 2'd1;
                    end
                end
                if (mcpt_pkg::TID_W'(r_pidx) == r_tgt) begin
                    r_sclk <= w_eff;
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_mode    <= w_item.mode;
                        r_tid     <= w_item.thread_id;
                        r_changed <= 1'b0;
                        r_cur     <= w_lo;
                        r_hi      <= w_lim;
                        r_tgt     <= w_item.thread_id;
                        r_idx     <= '0;
                        r_pv      <= 1'b0;
                        r_mcnt    <= '0;
                        r_vcnt    <= '0;
                        r_sclk    <= '0;
                        if (w_item.mode == mcpt_pkg::MODE_REMOVE) begin
                            r_final <= 1'b0;
                            r_state <= ST_NODE;
                        end else begin
                            r_final <= (w_item.mode != mcpt_pkg::MODE_ADVANCE);
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_pidx <= r_idx;
                    r_pv   <= 1'b1;
                    if (r_idx == IW'(THREADS - 1)) begin
                        r_state <= ST_SCAN_END;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                ST_SCAN_END: begin
                    r_pv <= 1'b0;
                    if (r_final) begin
                        r_state <= ST_REPORT;
                    end else if (r_mode == mcpt_pkg::MODE_ADVANCE) begin
                        r_state <= ST_ADVANCE;
                    end else begin
                        r_state <= ST_REMOVE;
                    end
                end
                ST_ADVANCE: begin
                    r_res.pad          <= '0;
                    r_res.thread_count <= mcpt_pkg::COUNT_W'(r_vcnt);
                    r_res.bad_thread   <= !w_tid_reg;
                    r_res.min_clock    <= (w_we && w_alone) ? r_min + CLK_W'(1) : r_min;
                    r_res.min_changed  <= w_we && w_alone;
                    r_res.thread_clock <= w_we ? w_next_clk : (w_tid_reg ? r_sclk : '0);
                    if (w_we) begin
                        r_written[r_tid[IW-1:0]] <= 1'b1;
                        if (w_alone) begin
                            r_min <= r_min + CLK_W'(1);
                        end
                    end
                    r_state <= ST_OUT;
                end
                ST_NODE: begin
                    r_idx  <= '0;
                    r_mcnt <= '0;
                    r_vcnt <= '0;
                    r_sclk <= '0;
                    if (r_cur >= r_hi) begin
                        // Range done: scan once more to report thread_id.
                        r_tgt   <= r_tid;
                        r_final <= 1'b1;
                        r_state <= ST_SCAN;
                    end else if (w_cur_reg) begin
                        r_tgt   <= mcpt_pkg::TID_W'(r_cur);
                        r_state <= ST_SCAN;
                    end else begin
                        r_cur <= r_cur + CUR_W'(1);
                    end
                end
                ST_REMOVE: begin
                    // Drop the thread; a lone minimum holder bumps the minimum unless it is saturated.
                    if (w_alone && r_min != mcpt_pkg::CLOCK_MAX) begin
                        r_min     <= r_min + CLK_W'(1);
                        r_changed <= 1'b1;
                    end
                    r_tvalid[r_tgt[IW-1:0]] <= 1'b0;
                    r_cur   <= r_cur + CUR_W'(1);
                    r_state <= ST_NODE;
                end
                ST_REPORT: begin
                    r_res.pad          <= '0;
                    r_res.thread_count <= mcpt_pkg::COUNT_W'(r_vcnt);
                    r_res.bad_thread   <= (r_mode != mcpt_pkg::MODE_REMOVE) && !w_tid_reg;
                    r_res.min_clock    <= r_min;
                    r_res.min_changed  <= r_changed;
                    r_res.thread_clock <= w_tid_reg ? r_sclk : '0;
                    r_state            <= ST_OUT;
                end
                ST_OUT: begin
                    // Hold the result until the output register frees up.
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // Loading the mask clears all clocks and the minimum.
            if (i_cfg_we) begin
                r_tvalid  <= i_cfg_wdata[THREADS-1:0];
                r_written <= '0;
                r_min     <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

// ===== rtl/core/mcpt_checker.sv =====
`include "min_clock_progress_tracker_macros.svh"

module mcpt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    mcpt_pkg::t_result w_res;

    assign w_res = mcpt_pkg::t_result'(m_axis_tdata);

    // One transaction at a time: busy right after an accept.
    `MCPT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A stalled result holds.
    `MCPT_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // An unknown thread changes nothing and reports a zero clock.
    `MCPT_ASSERT_IMP(a_bad_is_inert, i_clk, i_rst_n, m_axis_tvalid && w_res.bad_thread, !w_res.min_changed && w_res.thread_clock == '0)
    // A raised minimum cannot read as zero.
    `MCPT_ASSERT_IMP(a_raised_nonzero, i_clk, i_rst_n, m_axis_tvalid && w_res.min_changed, w_res.min_clock != '0)

endmodule

bind min_clock_progress_tracker mcpt_checker u_mcpt_checker (.*);
